[rtl/bdtp_pkg.sv]
`default_nettype none

package bdtp_pkg;

    // Reset value of the magnitude bound register.
    localparam logic [14:0] BOUND_RESET = 15'd1000;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Scale of one decimal digit.
    localparam logic [18:0] DEC_RADIX = 19'd10;

    // Where the parser stands within the current buffer.
    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_TRAIL  = 2'd3
    } phase_t;

    // One input character.
    typedef struct packed {
        logic [7:0] char_byte;
        logic       byte_present;
        logic       last_byte;
    } in_item_t;

    // One parse result.
    typedef struct packed {
        logic signed [15:0] parsed_value;
        logic               parse_error;
    } out_item_t;

    // Parse state carried from one character to the next.
    typedef struct packed {
        phase_t      phase;
        logic        negative;
        logic [14:0] magnitude;
        logic        failed;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '{
        phase:     PH_LEAD,
        negative:  1'b0,
        magnitude: 15'd0,
        failed:    1'b0
    };

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

[rtl/bdtp_step.sv]
`default_nettype none

module bdtp_step (
    input  wire bdtp_pkg::in_item_t     item,
    input  wire bdtp_pkg::parse_state_t state,
    input  wire logic [14:0]            bound,
    output bdtp_pkg::parse_state_t      state_next,
    output bdtp_pkg::out_item_t         result
);
    import bdtp_pkg::*;

    logic [18:0]  digit_sum;
    logic         digit_over;
    parse_state_t upd;
    logic         err;
    logic [15:0]  mag_ext;

    // Magnitude scaled by ten plus the new digit, checked against the bound.
    assign digit_sum  = 19'(state.magnitude) * DEC_RADIX + {15'd0, item.char_byte[3:0]};
    assign digit_over = digit_sum > {4'd0, bound};

    // Character classification and state update.
    always_comb
    begin
        upd = state;
        if (item.byte_present && !state.failed)
        begin
            unique case (state.phase)
                PH_LEAD:
                begin
                    if (is_ws(item.char_byte))
                    begin
                        upd.phase = PH_LEAD;
                    end
                    else if ((item.char_byte == CH_PLUS) || (item.char_byte == CH_MINUS))
                    begin
                        upd.negative = (item.char_byte == CH_MINUS);
                        upd.phase    = PH_SIGN;
                    end
                    else if (is_digit(item.char_byte))
                    begin
                        upd.phase = PH_DIGITS;
                        if (digit_over)
                            upd.failed = 1'b1;
                        else
                            upd.magnitude = digit_sum[14:0];
                    end
                    else
                    begin
                        upd.failed = 1'b1;
                    end
                end
                PH_SIGN, PH_DIGITS:
                begin
                    if (is_digit(item.char_byte))
                    begin
                        upd.phase = PH_DIGITS;
                        if (digit_over)
                            upd.failed = 1'b1;
                        else
                            upd.magnitude = digit_sum[14:0];
                    end
                    else if ((state.phase == PH_DIGITS) && is_ws(item.char_byte))
                    begin
                        upd.phase = PH_TRAIL;
                    end
                    else
                    begin
                        upd.failed = 1'b1;
                    end
                end
                PH_TRAIL:
                begin
                    if (!is_ws(item.char_byte))
                        upd.failed = 1'b1;
                end
            endcase
        end
    end

    // Result on the last character; the state starts afresh after it.
    assign err     = upd.failed || !((upd.phase == PH_DIGITS) || (upd.phase == PH_TRAIL));
    assign mag_ext = {1'b0, upd.magnitude};

    always_comb
    begin
        result.parse_error = err;
        if (err)
            result.parsed_value = 16'sd0;
        else if (upd.negative)
            result.parsed_value = $signed(16'd0 - mag_ext);
        else
            result.parsed_value = $signed(mag_ext);
        state_next = item.last_byte ? STATE_CLEAR : upd;
    end

endmodule

`default_nettype wire

[rtl/bounded_decimal_text_parser_core.sv]
// Signed decimal text parser with a programmable magnitude bound.
//
// The item channel carries one character of a text buffer per transfer,
// flagged with byte_present and last_byte; an empty buffer is one transfer
// with byte_present low and last_byte high. The result channel carries one
// transfer per buffer, on its last character: the signed value and an error
// flag (the value is zero on error).
// A character taken is held in the input register and parsed from there;
// for the last character the result is written to the result register.
// Throughput: one character per cycle unless a last character waits for
// the result register; the step logic's multiply by ten and add is combinational.
// While the receiver stalls a result, characters that are not the last of a
// buffer keep flowing; a last character waits in the input register until
// the result register is free.
// cfg_write_en writes the magnitude bound in the same edge, with no wait.
// Reset empties both registers, clears the parse state and sets the bound
// to 1000.
`default_nettype none

module bounded_decimal_text_parser_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire bdtp_pkg::in_item_t item,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output bdtp_pkg::out_item_t     result,
    input  wire logic               cfg_write_en,
    input  wire logic [14:0]        cfg_write_data
);
    import bdtp_pkg::*;

    logic         item_valid_reg;
    in_item_t     item_reg;
    logic         result_valid_reg;
    out_item_t    result_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic [14:0]  bound_reg;
    out_item_t    step_result;
    logic         result_free;
    logic         consume;

    // Per-character parse logic.
    bdtp_step u_step (
        .item       (item_reg),
        .state      (state_reg),
        .bound      (bound_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // Handshake: a held character moves on unless it needs a busy result slot.
    assign result_free = !result_valid_reg || result_ready;
    assign consume     = item_valid_reg && (!item_reg.last_byte || result_free);
    assign item_ready  = !item_valid_reg || consume;

    // Control state, parse state and the bound register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= STATE_CLEAR;
            bound_reg        <= BOUND_RESET;
        end
        else
        begin
            if (item_ready)
                item_valid_reg <= item_valid;
            if (consume)
                state_reg <= state_next;
            if (consume && item_reg.last_byte)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
            if (cfg_write_en)
                bound_reg <= cfg_write_data;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            item_reg <= item;
        if (consume && item_reg.last_byte)
            result_reg <= step_result;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // An error result always carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.parse_error |-> result_reg.parsed_value == 16'sd0)
        else $error("error result with a non-zero value");

    // A valid result never reaches the most negative code.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> result_reg.parsed_value != 16'sh8000)
        else $error("result value out of range");

    // The parse state starts afresh after the last character of a buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        consume && item_reg.last_byte |=>
            (state_reg.phase == PH_LEAD) && !state_reg.failed &&
            (state_reg.magnitude == 15'd0) && !state_reg.negative)
        else $error("parse state not cleared after end of buffer");

    // A stalled result is never overwritten by the next buffer's result.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_ready |-> !(consume && item_reg.last_byte))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire
